### hw/rtl/alfr_pkg.sv
// ----------------------------------------------------------------------------
// Lagged Fibonacci generator package
// Shared types, codes and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package alfr_pkg;

  localparam int WORD_W = 32;
  localparam int STEP_W = 7;

  // Request operation codes.
  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  // Output format codes.
  localparam logic [1:0] FMT_FULL = 2'd0;
  localparam logic [1:0] FMT_HALF = 2'd1;
  localparam logic [1:0] FMT_FRAC = 2'd2;

  localparam logic [WORD_W-1:0] SEED_MUL      = 32'd13;
  localparam logic [WORD_W-1:0] SEED_ADD      = 32'd3;
  localparam logic [WORD_W-1:0] FRACTION_MASK = 32'h00FF_FFFF;
  localparam logic [STEP_W-1:0] SILENT_DRAWS  = 7'd100;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_seed;   // latch seed into the fill generator, zero the position
    logic fill_write;  // write the fill word at the position, advance
    logic rd;          // read the source and destination words
    logic wr;          // write the sum back to the destination, advance
    logic capture;     // latch the format of an accepted draw request
    logic out_load;    // load the result register
  } alfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_last;     // position is at the last ring entry
    logic out_blocked;  // result register is full and stalled
  } alfr_status_t;

endpackage

`default_nettype wire

### hw/rtl/additive_lagged_fibonacci_rng.sv
// ----------------------------------------------------------------------------
// Additive lagged Fibonacci random number generator
// Ring of 32-bit words in RAM; a draw adds the read word into the word LAG
// places ahead, writes it back and returns the sum in the requested format.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid / in_stall     operation, format
//   out      output     out_valid / out_stall   value
//   cfg      input      cfg_valid / cfg_ready   seed
//
// An accepted draw reads the ring, then sums the registered RAM read data, writes
// the sum back and loads the result register; no new request is taken until the
// draw has returned to idle.
// A reseed fills every ring entry and then runs 100 silent draws.
// Reset runs a reseed with seed zero; in_stall is high while it runs.
// A stalled output holds the draw in its write-back cycle until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module additive_lagged_fibonacci_rng
  import alfr_pkg::*;
#(
  parameter int RING_DEPTH = 55,
  parameter int LAG        = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              operation,
  input  wire logic [1:0]        format,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [WORD_W-1:0] value,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [WORD_W-1:0] seed
);

  alfr_cmd_t    cmd;
  alfr_status_t status;

  assign cfg_ready = 1'b1;

  alfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .status    (status),
    .cmd       (cmd)
  );

  alfr_datapath #(
    .RING_DEPTH (RING_DEPTH),
    .LAG        (LAG)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .seed      (seed),
    .format    (format),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value)
  );

endmodule

`default_nettype wire

### hw/rtl/alfr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module alfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 55
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/alfr_ctrl.sv
// ----------------------------------------------------------------------------
// Lagged Fibonacci generator controller
// Sequences ring fill, silent draws of a reseed and requested draws.
// ----------------------------------------------------------------------------
`default_nettype none

module alfr_ctrl
  import alfr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic         operation,
  input  wire alfr_status_t status,
  output alfr_cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_READ,
    S_WRITE
  } state_t;

  state_t            state;
  state_t            state_next;
  logic              silent;
  logic              silent_next;
  logic [STEP_W-1:0] step_count;
  logic [STEP_W-1:0] step_count_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd             = '0;
    state_next      = state;
    silent_next     = silent;
    step_count_next = step_count;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (operation == OP_RESEED) begin
            cmd.load_seed = 1'b1;
            state_next    = S_FILL;
          end else begin
            cmd.capture = 1'b1;
            silent_next = 1'b0;
            state_next  = S_READ;
          end
        end
      end
      S_FILL: begin
        cmd.fill_write = 1'b1;
        if (status.pos_last) begin
          silent_next     = 1'b1;
          step_count_next = '0;
          state_next      = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (silent) begin
          cmd.wr = 1'b1;
          if (step_count == SILENT_DRAWS - 7'd1) begin
            step_count_next = '0;
            state_next      = S_IDLE;
          end else begin
            step_count_next = step_count + 7'd1;
            state_next      = S_READ;
          end
        end else if (!status.out_blocked) begin
          cmd.wr       = 1'b1;
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Reset starts a reseed with the seed register at zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      silent     <= 1'b1;
      step_count <= '0;
    end else begin
      state      <= state_next;
      silent     <= silent_next;
      step_count <= step_count_next;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step_count < SILENT_DRAWS)
    else $error("silent draw count out of range");

  a_draw_reads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && operation == OP_DRAW) |=> cmd.rd)
    else $error("accepted draw did not read the ring next cycle");

  a_result_only_user: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (cmd.wr && !silent))
    else $error("result loaded outside a requested draw");

endmodule

`default_nettype wire

### hw/rtl/alfr_datapath.sv
// ----------------------------------------------------------------------------
// Lagged Fibonacci generator datapath
// Seed register, fill generator, ring position, lag adder and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module alfr_datapath
  import alfr_pkg::*;
#(
  parameter int RING_DEPTH = 55,
  parameter int LAG        = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic [WORD_W-1:0] seed,
  input  wire logic [1:0]        format,
  input  wire alfr_cmd_t         cmd,
  output alfr_status_t           status,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [WORD_W-1:0] value
);

  localparam int PW      = $clog2(RING_DEPTH);
  localparam int LAG_MOD = LAG % RING_DEPTH;

  logic [WORD_W-1:0] seed_reg;
  logic [WORD_W-1:0] fill_word;
  logic [PW-1:0]     pos;
  logic [PW-1:0]     pos_inc;
  logic [PW:0]       dst_wide;
  logic [PW-1:0]     dst;
  logic [1:0]        fmt;
  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] result;
  logic              ram_we;
  logic [PW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;

  assign status.pos_last    = (pos == PW'(RING_DEPTH - 1));
  assign status.out_blocked = out_valid && out_stall;

  assign pos_inc  = status.pos_last ? '0 : pos + PW'(1);
  assign dst_wide = {1'b0, pos} + (PW + 1)'(LAG_MOD);
  assign dst      = (dst_wide >= (PW + 1)'(RING_DEPTH))
                    ? PW'(dst_wide - (PW + 1)'(RING_DEPTH)) : dst_wide[PW-1:0];

  assign sum = rdata_a + rdata_b;

  always_comb begin
    unique case (fmt)
      FMT_HALF: result = sum >> 1;
      FMT_FRAC: result = (sum >> 1) & FRACTION_MASK;
      default:  result = sum;
    endcase
  end

  assign ram_we    = cmd.fill_write || cmd.wr;
  assign ram_waddr = cmd.fill_write ? pos : dst;
  assign ram_wdata = cmd.fill_write ? fill_word : sum;

  alfr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (cmd.rd),
    .raddr_a (pos),
    .raddr_b (dst),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // The fill word and position reset to the state a reseed with zero starts from.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_reg  <= '0;
      fill_word <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        seed_reg <= seed;
      end
      if (cmd.load_seed) begin
        fill_word <= seed_reg;
        pos       <= '0;
      end else if (cmd.fill_write) begin
        fill_word <= fill_word * SEED_MUL + SEED_ADD;
        pos       <= pos_inc;
      end else if (cmd.wr) begin
        pos <= pos_inc;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fmt <= format;
    end
    if (cmd.out_load) begin
      value <= result;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos < PW'(RING_DEPTH - 1) || status.pos_last)
    else $error("ring position beyond depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !status.out_blocked)
    else $error("result register overwritten while stalled");

  // A requested draw may wait on a stalled result between its read and its write-back.
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> ($past(cmd.rd) || $past(status.out_blocked)))
    else $error("ring write-back without a preceding read");

endmodule

`default_nettype wire
